[rtl/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[rtl/i2cbm_pkg.sv]
package i2cbm_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TDATA_IN_W = 16;
    localparam int TUSER_IN_W = 3;
    localparam int TDATA_OUT_W = 16;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd8;
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Command codes.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Register index of the configuration port.
    localparam logic REG_HALF_PERIOD = 1'b0;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_SEG1 = 5'b00010,
        PH_SEG2 = 5'b00100,
        PH_SEG3 = 5'b01000,
        PH_SEG4 = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  bit_cnt;
        logic [15:0] delay_cnt;
        logic [7:0]  shift_byte;
        logic        scl;
        logic        sda;
        logic        sda_en;
        logic        ack;
        logic [1:0]  kind;
        logic [7:0]  last_rd;
    } t_state;

    typedef struct packed {
        logic       sda_in;
        logic       ack_flag;
        logic [7:0] wr_data;
        logic [1:0] req_type;
        logic       cmd_valid;
    } t_in;

    typedef struct packed {
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       busy_res;
        logic       sda_oe;
        logic       sda_out;
        logic       scl;
    } t_out;

    typedef struct packed {
        logic scl;
        logic sda;
        logic sda_en;
    } t_lines;

    localparam int OUT_W = $bits(t_out);

    function automatic t_phase next_phase(input t_phase ph);
        t_phase res;
        case (ph)
            PH_SEG1: res = PH_SEG2;
            PH_SEG2: res = PH_SEG3;
            PH_SEG3: res = PH_SEG4;
            default: res = PH_IDLE;
        endcase
        return res;
    endfunction

    // Line levels on entry to a segment of a command.
    function automatic t_lines segment_lines(input logic [1:0] kind, input t_phase ph,
                                             input logic wbit, input logic ack,
                                             input t_lines cur);
        t_lines res;
        res = cur;
        case (kind)
            KIND_START: begin
                if (ph == PH_SEG1) begin
                    res.sda = 1'b1;
                    res.sda_en = 1'b1;
                end else if (ph == PH_SEG2) begin
                    res.scl = 1'b1;
                end else begin
                    res.sda = 1'b0;
                end
            end
            KIND_STOP: begin
                if (ph == PH_SEG1) begin
                    res.scl = 1'b0;
                    res.sda = 1'b0;
                    res.sda_en = 1'b1;
                end else if (ph == PH_SEG2) begin
                    res.scl = 1'b1;
                end else begin
                    res.sda = 1'b1;
                end
            end
            KIND_WRITE: begin
                if (ph == PH_SEG1) begin
                    res.scl = 1'b0;
                    res.sda = wbit;
                    res.sda_en = 1'b1;
                end else if (ph == PH_SEG3) begin
                    res.scl = 1'b0;
                    res.sda = 1'b1;
                    res.sda_en = 1'b1;
                end else begin
                    res.scl = 1'b1;
                end
            end
            default: begin
                if (ph == PH_SEG1) begin
                    res.scl = 1'b0;
                    res.sda = 1'b1;
                    res.sda_en = 1'b0;
                end else if (ph == PH_SEG3) begin
                    res.scl = 1'b0;
                    res.sda = ack;
                    res.sda_en = 1'b1;
                end else begin
                    res.scl = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

endpackage

[rtl/i2c_bit_level_master_top.sv]
// An accepted tick's result is registered and reaches the master side in the next cycle.
// Throughput: one tick per cycle when not stalled; the line sequencer updates in one pass.
// A stalled result is held in the output register; input is taken once it drains.
// Reset (synchronous, active low) idles the sequencer with SCL and SDA high and driven,
// clears the read byte and loads a half period of eight ticks.
`include "assert_macros.svh"

module i2c_bit_level_master_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Tick transactions from the controller side.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, lowest bit first: wr_data[7:0], ack_flag, sda_in, zero padding.
    input  logic [i2cbm_pkg::TDATA_IN_W-1:0]       s_axis_tdata,
    // tuser, lowest bit first: cmd_valid, req_type[1:0].
    input  logic [i2cbm_pkg::TUSER_IN_W-1:0]       s_axis_tuser,
    // Line and status results.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, lowest bit first: scl, sda_out, sda_oe, busy_res, rd_data[7:0], rd_valid,
    // zero padding.
    output logic [i2cbm_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,
    // Configuration register port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [i2cbm_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [i2cbm_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [i2cbm_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                   pready
);

    // The half period register sits at byte address zero; bit 2 picks the register.
    logic        cfg_sel;
    logic        cfg_wr;
    logic [15:0] r_half_period;

    assign pready = 1'b1;
    assign cfg_sel = (paddr[2] == i2cbm_pkg::REG_HALF_PERIOD);
    assign cfg_wr = psel && penable && pwrite && cfg_sel;
    assign prdata = cfg_sel ? {16'd0, r_half_period} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cbm_pkg::HALF_PERIOD_RESET;
        end else if (cfg_wr) begin
            r_half_period <= pwdata[15:0];
        end
    end

    // A tick transaction is taken whenever the result register can hold its result.
    logic              in_accept;
    logic              out_room;
    i2cbm_pkg::t_in    item;
    i2cbm_pkg::t_state r_state;
    i2cbm_pkg::t_state n_state;
    i2cbm_pkg::t_out   result;
    i2cbm_pkg::t_out   out_data;

    assign s_axis_tready = out_room;
    assign in_accept = s_axis_tvalid && out_room;

    assign item.cmd_valid = s_axis_tuser[0];
    assign item.req_type = s_axis_tuser[2:1];
    assign item.wr_data = s_axis_tdata[7:0];
    assign item.ack_flag = s_axis_tdata[8];
    assign item.sda_in = s_axis_tdata[9];

    // The whole per-tick update of the sequencer is one combinational pass.
    i2cbm_step u_step (
        .i_state       (r_state),
        .i_item        (item),
        .i_half_period (r_half_period),
        .o_state       (n_state),
        .o_result      (result)
    );

    // The sequencer state advances only on accepted ticks, so stalls freeze line timing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= i2cbm_pkg::PH_IDLE;
            r_state.bit_cnt <= 3'd0;
            r_state.delay_cnt <= 16'd0;
            r_state.shift_byte <= 8'd0;
            r_state.scl <= 1'b1;
            r_state.sda <= 1'b1;
            r_state.sda_en <= 1'b1;
            r_state.ack <= 1'b1;
            r_state.kind <= i2cbm_pkg::KIND_START;
            r_state.last_rd <= 8'd0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // The output register decouples the master side so input keeps flowing.
    i2cbm_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_accept),
        .i_data      (result),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (out_data),
        .o_accept_ok (out_room)
    );

    assign m_axis_tdata = {{(i2cbm_pkg::TDATA_OUT_W - i2cbm_pkg::OUT_W){1'b0}}, out_data};

    // A completed read always reports the sequencer as no longer busy.
    `ASSERT_NEVER(a_rdvalid_not_busy, i_clk, i_rst_n, m_axis_tvalid && out_data.rd_valid && out_data.busy_res, "read completion shown while busy")
    // Input is refused only while a result is waiting and the master side stalls.
    `ASSERT_ALWAYS(a_ready_only_on_stall, i_clk, i_rst_n, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input refused without an output stall")
    // A command taken while idle makes the next result busy.
    `ASSERT_ALWAYS(a_cmd_sets_busy, i_clk, i_rst_n, (in_accept && item.cmd_valid && r_state.phase == i2cbm_pkg::PH_IDLE) |=> (m_axis_tvalid && out_data.busy_res), "command load did not start a sequence")

endmodule

[rtl/i2cbm_step.sv]
module i2cbm_step (
    input  i2cbm_pkg::t_state i_state,
    input  i2cbm_pkg::t_in    i_item,
    input  logic [15:0]       i_half_period,
    output i2cbm_pkg::t_state o_state,
    output i2cbm_pkg::t_out   o_result
);

    logic [15:0]       period;
    logic              expire;
    logic              done;
    logic              enter;
    logic              rd_valid;
    logic              wbit;
    i2cbm_pkg::t_state ns;
    i2cbm_pkg::t_lines lines;

    assign period = (i_half_period == 16'd0) ? 16'd1 : i_half_period;
    assign expire = ({1'b0, i_state.delay_cnt} + 17'd1) >= {1'b0, period};

    always_comb begin
        ns = i_state;
        done = 1'b0;
        enter = 1'b0;
        rd_valid = 1'b0;
        if (i_state.phase == i2cbm_pkg::PH_IDLE) begin
            if (i_item.cmd_valid) begin
                ns.kind = i_item.req_type;
                ns.shift_byte = (i_item.req_type == i2cbm_pkg::KIND_WRITE) ?
                                i_item.wr_data : 8'd0;
                ns.ack = ~i_item.ack_flag;
                ns.bit_cnt = 3'd0;
                ns.delay_cnt = 16'd0;
                ns.phase = i2cbm_pkg::PH_SEG1;
                enter = 1'b1;
            end
        end else if (expire) begin
            ns.delay_cnt = 16'd0;
            if (i_state.kind == i2cbm_pkg::KIND_START || i_state.kind == i2cbm_pkg::KIND_STOP)
            begin
                if (i_state.phase == i2cbm_pkg::PH_SEG3) begin
                    done = 1'b1;
                end else begin
                    ns.phase = i2cbm_pkg::next_phase(i_state.phase);
                    enter = 1'b1;
                end
            end else if (i_state.phase == i2cbm_pkg::PH_SEG2) begin
                if (i_state.bit_cnt != i2cbm_pkg::LAST_BIT) begin
                    ns.bit_cnt = i_state.bit_cnt + 3'd1;
                    ns.phase = i2cbm_pkg::PH_SEG1;
                end else begin
                    ns.phase = i2cbm_pkg::PH_SEG3;
                end
                enter = 1'b1;
            end else if (i_state.phase == i2cbm_pkg::PH_SEG4) begin
                done = 1'b1;
            end else begin
                ns.phase = i2cbm_pkg::next_phase(i_state.phase);
                enter = 1'b1;
            end
        end else begin
            ns.delay_cnt = i_state.delay_cnt + 16'd1;
        end

        if (done) begin
            ns.phase = i2cbm_pkg::PH_IDLE;
            if (i_state.kind == i2cbm_pkg::KIND_WRITE || i_state.kind == i2cbm_pkg::KIND_READ)
            begin
                ns.scl = 1'b0;
            end
            if (i_state.kind == i2cbm_pkg::KIND_READ) begin
                ns.last_rd = i_state.shift_byte;
                rd_valid = 1'b1;
            end
        end

        wbit = ns.shift_byte[i2cbm_pkg::LAST_BIT - ns.bit_cnt];
        lines = i2cbm_pkg::segment_lines(ns.kind, ns.phase, wbit, ns.ack,
                                         '{scl: ns.scl, sda: ns.sda, sda_en: ns.sda_en});
        if (enter) begin
            ns.scl = lines.scl;
            ns.sda = lines.sda;
            ns.sda_en = lines.sda_en;
        end

        // The read byte is sampled on every tick of a data bit's high phase.
        if (ns.kind == i2cbm_pkg::KIND_READ && ns.phase == i2cbm_pkg::PH_SEG2) begin
            ns.shift_byte[i2cbm_pkg::LAST_BIT - ns.bit_cnt] = i_item.sda_in;
        end
    end

    assign o_state = ns;
    assign o_result.scl = ns.scl;
    assign o_result.sda_out = ns.sda_en ? ns.sda : 1'b1;
    assign o_result.sda_oe = ns.sda_en;
    assign o_result.busy_res = (ns.phase != i2cbm_pkg::PH_IDLE);
    assign o_result.rd_data = ns.last_rd;
    assign o_result.rd_valid = rd_valid;

endmodule

[rtl/i2cbm_out_reg.sv]
module i2cbm_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [i2cbm_pkg::OUT_W-1:0]   i_data,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [i2cbm_pkg::OUT_W-1:0]   o_data,
    output logic                          o_accept_ok
);

    logic                        r_valid;
    logic                        n_valid;
    logic [i2cbm_pkg::OUT_W-1:0] r_data;

    // A new result may enter when the register is empty or drains this cycle.
    assign o_accept_ok = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data = r_data;

endmodule

[bench/tb_i2c_bit_level_master_top.sv]
`timescale 1ns / 1ps

module tb_i2c_bit_level_master_top;

    // A watchdog ends the run when no transaction moves on either stream for this long.
    // The slowest healthy stretch is a random sender gap or receiver stall plus register access.
    localparam int QUIET_LIMIT = 2000;
    // Minimum number of tick transactions per randomized half-period setting.
    localparam int PHASE_TICKS = 60;
    // Half-period settings for the randomized part. Two upper halves carry junk to show
    // that only 16 bits are kept, and a zero setting must behave like one tick.
    localparam logic [31:0] RAND_HALF_PERIODS [7] = '{
        32'hFFFF_0000, 32'd1, 32'd2, 32'h5A5A_0003, 32'd4, 32'd6, 32'd1
    };
    // Directed rows from this one on run at a two-tick half period.
    localparam int DIR_FAST_FROM = 2;

    // One row of the directed table. Where typed is set, the row's expectation for the tick
    // on which the line goes idle is the literal want instead of the predictor's output.
    // The want fields from the top down: rd_valid, rd_data, busy_res, sda_oe, sda_out, scl.
    typedef struct packed {
        logic            is_cmd;
        logic [1:0]      kind;
        logic [7:0]      data;
        logic            ack;
        logic [7:0]      line_byte;
        logic            typed;
        i2cbm_pkg::t_out want;
    } t_dir_row;

    localparam int DIR_ROWS = 19;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // The first tick after reset: both lines high and driven, nothing read yet.
        '{1'b0, i2cbm_pkg::KIND_START, 8'h00, 1'b0, 8'h00, 1'b1,
          {1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{1'b1, i2cbm_pkg::KIND_START, 8'h00, 1'b0, 8'h00, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_WRITE, 8'h00, 1'b0, 8'h00, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_WRITE, 8'hA5, 1'b0, 8'h3C, 1'b0, 13'd0},
        // Reads end with SCL low and SDA driven to the ACK or NACK level.
        '{1'b1, i2cbm_pkg::KIND_READ,  8'hFF, 1'b1, 8'h5A, 1'b1,
          {1'b1, 8'h5A, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{1'b1, i2cbm_pkg::KIND_READ,  8'h00, 1'b0, 8'hFF, 1'b1,
          {1'b1, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{1'b1, i2cbm_pkg::KIND_READ,  8'hFF, 1'b1, 8'h00, 1'b1,
          {1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{1'b1, i2cbm_pkg::KIND_STOP,  8'hFF, 1'b1, 8'hFF, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_STOP,  8'h00, 1'b0, 8'h00, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_START, 8'hFF, 1'b1, 8'hFF, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_START, 8'h55, 1'b0, 8'hAA, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_READ,  8'h00, 1'b0, 8'h81, 1'b1,
          {1'b1, 8'h81, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{1'b1, i2cbm_pkg::KIND_WRITE, 8'h3C, 1'b1, 8'h00, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_STOP,  8'h00, 1'b1, 8'h00, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_WRITE, 8'h80, 1'b0, 8'h00, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_READ,  8'h01, 1'b1, 8'hC3, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_START, 8'h00, 1'b0, 8'h00, 1'b0, 13'd0},
        '{1'b1, i2cbm_pkg::KIND_STOP,  8'h00, 1'b0, 8'h00, 1'b0, 13'd0}
    };

    // Predicted state of the line sequencer.
    typedef struct packed {
        i2cbm_pkg::t_phase seg;
        logic [2:0]        bit_idx;
        logic [15:0]       hold;
        logic [7:0]        shreg;
        logic              scl;
        logic              sda;
        logic              sda_en;
        logic              ack_lvl;
        logic [1:0]        cmd;
        logic [7:0]        rd_byte;
    } t_line_state;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [i2cbm_pkg::TDATA_IN_W-1:0]   s_axis_tdata;
    logic [i2cbm_pkg::TUSER_IN_W-1:0]   s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [i2cbm_pkg::TDATA_OUT_W-1:0]  m_axis_tdata;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [i2cbm_pkg::CFG_ADDR_W-1:0]   paddr;
    logic [i2cbm_pkg::CFG_DATA_W-1:0]   pwdata;
    logic [i2cbm_pkg::CFG_DATA_W-1:0]   prdata;
    logic                               pready;

    // Predictor state, its copy of the half-period register, and the results it expects.
    t_line_state     line;
    logic [15:0]     half_period;
    i2cbm_pkg::t_out expected_lines [$];

    bit idle_on;
    int errors;
    int ticks_sent;
    int cmds_issued;
    int reads_seen;
    int results_checked;
    int settings_used;
    int quiet_cycles;
    int stall_left;
    i2cbm_pkg::t_out got_line;
    i2cbm_pkg::t_out want_line;

    i2c_bit_level_master_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A setting of zero holds every segment for a single tick.
    function automatic logic [15:0] line_period();
        return (half_period == 16'd0) ? 16'd1 : half_period;
    endfunction

    // Drive the SCL/SDA levels that belong to the segment the sequencer has just entered.
    function automatic void set_segment(inout t_line_state st);
        logic wbit;
        wbit = st.shreg[i2cbm_pkg::LAST_BIT - st.bit_idx];
        case (st.cmd)
            i2cbm_pkg::KIND_START: begin
                if (st.seg == i2cbm_pkg::PH_SEG1) begin
                    st.sda = 1'b1;
                    st.sda_en = 1'b1;
                end else if (st.seg == i2cbm_pkg::PH_SEG2) begin
                    st.scl = 1'b1;
                end else begin
                    st.sda = 1'b0;
                end
            end
            i2cbm_pkg::KIND_STOP: begin
                if (st.seg == i2cbm_pkg::PH_SEG1) begin
                    st.scl = 1'b0;
                    st.sda = 1'b0;
                    st.sda_en = 1'b1;
                end else if (st.seg == i2cbm_pkg::PH_SEG2) begin
                    st.scl = 1'b1;
                end else begin
                    st.sda = 1'b1;
                end
            end
            i2cbm_pkg::KIND_WRITE: begin
                if (st.seg == i2cbm_pkg::PH_SEG1) begin
                    st.scl = 1'b0;
                    st.sda = wbit;
                    st.sda_en = 1'b1;
                end else if (st.seg == i2cbm_pkg::PH_SEG3) begin
                    // Ninth clock: SDA stays driven high, the slave ACK is not looked at.
                    st.scl = 1'b0;
                    st.sda = 1'b1;
                    st.sda_en = 1'b1;
                end else begin
                    st.scl = 1'b1;
                end
            end
            default: begin
                if (st.seg == i2cbm_pkg::PH_SEG1) begin
                    st.scl = 1'b0;
                    st.sda = 1'b1;
                    st.sda_en = 1'b0;
                end else if (st.seg == i2cbm_pkg::PH_SEG3) begin
                    st.scl = 1'b0;
                    st.sda = st.ack_lvl;
                    st.sda_en = 1'b1;
                end else begin
                    st.scl = 1'b1;
                end
            end
        endcase
    endfunction

    // Advance the sequencer by one tick and give the line levels shown on that tick.
    function automatic void tick_line(inout t_line_state st, input i2cbm_pkg::t_in x,
                                      output i2cbm_pkg::t_out res);
        logic [15:0] per;
        logic        done;
        logic        rdv;
        per = line_period();
        done = 1'b0;
        rdv = 1'b0;
        if (st.seg == i2cbm_pkg::PH_IDLE) begin
            if (x.cmd_valid) begin
                st.cmd = x.req_type;
                st.shreg = (x.req_type == i2cbm_pkg::KIND_WRITE) ? x.wr_data : 8'd0;
                st.ack_lvl = ~x.ack_flag;
                st.bit_idx = 3'd0;
                st.hold = 16'd0;
                st.seg = i2cbm_pkg::PH_SEG1;
                set_segment(st);
            end
        end else if ({1'b0, st.hold} + 17'd1 >= {1'b0, per}) begin
            st.hold = 16'd0;
            case (st.seg)
                i2cbm_pkg::PH_SEG1: st.seg = i2cbm_pkg::PH_SEG2;
                i2cbm_pkg::PH_SEG2: begin
                    if (st.cmd == i2cbm_pkg::KIND_START || st.cmd == i2cbm_pkg::KIND_STOP) begin
                        st.seg = i2cbm_pkg::PH_SEG3;
                    end else if (st.bit_idx < i2cbm_pkg::LAST_BIT) begin
                        st.bit_idx = st.bit_idx + 3'd1;
                        st.seg = i2cbm_pkg::PH_SEG1;
                    end else begin
                        st.seg = i2cbm_pkg::PH_SEG3;
                    end
                end
                i2cbm_pkg::PH_SEG3: begin
                    if (st.cmd == i2cbm_pkg::KIND_START || st.cmd == i2cbm_pkg::KIND_STOP) begin
                        done = 1'b1;
                    end else begin
                        st.seg = i2cbm_pkg::PH_SEG4;
                    end
                end
                default: done = 1'b1;
            endcase
            if (done) begin
                st.seg = i2cbm_pkg::PH_IDLE;
                if (st.cmd == i2cbm_pkg::KIND_WRITE || st.cmd == i2cbm_pkg::KIND_READ) begin
                    st.scl = 1'b0;
                end
                if (st.cmd == i2cbm_pkg::KIND_READ) begin
                    st.rd_byte = st.shreg;
                    rdv = 1'b1;
                end
            end else begin
                set_segment(st);
            end
        end else begin
            st.hold = st.hold + 16'd1;
        end
        // A read samples SDA on every SCL-high tick of a data bit; the last sample stays.
        if (st.cmd == i2cbm_pkg::KIND_READ && st.seg == i2cbm_pkg::PH_SEG2) begin
            st.shreg[i2cbm_pkg::LAST_BIT - st.bit_idx] = x.sda_in;
        end
        res.scl = st.scl;
        res.sda_out = st.sda_en ? st.sda : 1'b1;
        res.sda_oe = st.sda_en;
        res.busy_res = (st.seg != i2cbm_pkg::PH_IDLE);
        res.rd_data = st.rd_byte;
        res.rd_valid = rdv;
    endfunction

    // Offer one tick transaction, wait for the handshake, then record what it should produce.
    // We enter and leave at a rising edge, so each signal gets one assignment per step.
    task automatic send_tick(input i2cbm_pkg::t_in x, input bit typed_on,
                             input i2cbm_pkg::t_out typed_val);
        i2cbm_pkg::t_out pred;
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, x.sda_in, x.ack_flag, x.wr_data};
        s_axis_tuser <= {x.req_type, x.cmd_valid};
        do @(posedge i_clk); while (!s_axis_tready);
        tick_line(line, x, pred);
        // A typed expectation replaces the prediction on the tick where the line is idle.
        expected_lines.push_back((typed_on && line.seg == i2cbm_pkg::PH_IDLE) ?
                                 typed_val : pred);
        ticks_sent++;
    endtask

    // A tick with no command; the other fields are noise.
    task automatic idle_tick(input bit typed_on, input i2cbm_pkg::t_out typed_val);
        i2cbm_pkg::t_in x;
        x.cmd_valid = 1'b0;
        x.req_type = 2'($urandom_range(0, 3));
        x.wr_data = 8'($urandom_range(0, 255));
        x.ack_flag = 1'($urandom_range(0, 1));
        x.sda_in = 1'($urandom_range(0, 1));
        send_tick(x, typed_on, typed_val);
    endtask

    // Load one command and keep ticking until the sequencer is idle again. The ticks in
    // between carry random commands, which must be ignored while busy, the completion tick
    // included. With glitch set, SDA shows the wanted bit only on the last SCL-high tick of
    // each read bit and its inverse before, so only the final sample can give line_byte.
    task automatic run_command(input logic [1:0] kind, input logic [7:0] data,
                               input logic ack, input logic [7:0] line_byte,
                               input bit glitch, input bit typed_on,
                               input i2cbm_pkg::t_out typed_val);
        i2cbm_pkg::t_in  x;
        t_line_state     trial;
        i2cbm_pkg::t_out unused;
        logic            last_high;
        x.cmd_valid = 1'b1;
        x.req_type = kind;
        x.wr_data = data;
        x.ack_flag = ack;
        x.sda_in = 1'($urandom_range(0, 1));
        send_tick(x, typed_on, typed_val);
        cmds_issued++;
        while (line.seg != i2cbm_pkg::PH_IDLE) begin
            x.cmd_valid = 1'($urandom_range(0, 1));
            x.req_type = 2'($urandom_range(0, 3));
            x.wr_data = 8'($urandom_range(0, 255));
            x.ack_flag = 1'($urandom_range(0, 1));
            x.sda_in = 1'b0;
            trial = line;
            tick_line(trial, x, unused);
            if (glitch) begin
                last_high = (trial.seg == i2cbm_pkg::PH_SEG2) &&
                            (trial.hold == line_period() - 16'd1);
                x.sda_in = line_byte[i2cbm_pkg::LAST_BIT - trial.bit_idx] ^ ~last_high;
            end else begin
                x.sda_in = 1'($urandom_range(0, 1));
            end
            send_tick(x, typed_on, typed_val);
        end
    endtask

    task automatic random_command(input logic [1:0] kind);
        run_command(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)), $urandom_range(0, 2) != 0, 1'b0, 13'd0);
    endtask

    // A well-formed bus frame: start, address byte, up to three data bytes either way, stop.
    task automatic run_frame();
        int n;
        n = $urandom_range(0, 3);
        random_command(i2cbm_pkg::KIND_START);
        random_command(i2cbm_pkg::KIND_WRITE);
        repeat (n) begin
            random_command($urandom_range(0, 1) ? i2cbm_pkg::KIND_WRITE :
                                                  i2cbm_pkg::KIND_READ);
        end
        random_command(i2cbm_pkg::KIND_STOP);
    endtask

    // Let the block drain completely, then write the half period and read it back.
    // The sequencer is always idle here because every command runs to completion.
    task automatic set_half_period(input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {i2cbm_pkg::REG_HALF_PERIOD, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        half_period = value[15:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'd0, value[15:0]}) begin
            $error("half_period_ticks readback: expected %0h, actual %0h",
                   {16'd0, value[15:0]}, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    // Result side: every accepted result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_line = i2cbm_pkg::t_out'(m_axis_tdata[i2cbm_pkg::OUT_W-1:0]);
            if (expected_lines.size() == 0) begin
                $error("result with no expectation waiting: %0h", got_line);
                errors++;
            end else begin
                want_line = expected_lines.pop_front();
                check_field("scl", want_line.scl, got_line.scl);
                check_field("sda_out", want_line.sda_out, got_line.sda_out);
                check_field("sda_oe", want_line.sda_oe, got_line.sda_oe);
                check_field("busy_res", want_line.busy_res, got_line.busy_res);
                check_field("rd_data", want_line.rd_data, got_line.rd_data);
                check_field("rd_valid", want_line.rd_valid, got_line.rd_valid);
            end
            results_checked++;
            if (got_line.rd_valid) begin
                reads_seen++;
            end
        end
    end

    // The receiver stalls in random bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: counts consecutive cycles in which neither stream moves a transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("i2c_bit_level_master_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : main
        int phase_start;
        int pick;
        // Every input is known from time zero; reset is asserted only once, at the start.
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_on = 1'b1;
        errors = 0;
        ticks_sent = 0;
        cmds_issued = 0;
        reads_seen = 0;
        results_checked = 0;
        settings_used = 0;
        quiet_cycles = 0;
        stall_left = 0;
        // The predictor starts from the reset state of the sequencer.
        line = '0;
        line.seg = i2cbm_pkg::PH_IDLE;
        line.scl = 1'b1;
        line.sda = 1'b1;
        line.sda_en = 1'b1;
        line.ack_lvl = 1'b1;
        half_period = i2cbm_pkg::HALF_PERIOD_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. The reset check and the first start run at the reset half
        // period of eight ticks; the other rows use two ticks, so every SCL-high phase
        // still takes more than one sample.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == DIR_FAST_FROM) begin
                set_half_period(32'd2);
            end
            if (!DIRECTED[i].is_cmd) begin
                idle_tick(DIRECTED[i].typed, DIRECTED[i].want);
            end else begin
                run_command(DIRECTED[i].kind, DIRECTED[i].data, DIRECTED[i].ack,
                            DIRECTED[i].line_byte, 1'b1, DIRECTED[i].typed,
                            DIRECTED[i].want);
            end
        end

        // Randomized part: mostly complete frames with random content, some lone
        // commands of any kind, and short runs of empty ticks.
        foreach (RAND_HALF_PERIODS[p]) begin
            set_half_period(RAND_HALF_PERIODS[p]);
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS) begin
                pick = $urandom_range(0, 19);
                if (pick < 13) begin
                    run_frame();
                end else if (pick < 17) begin
                    random_command(2'($urandom_range(0, 3)));
                end else begin
                    repeat ($urandom_range(1, 4)) idle_tick(1'b0, 13'd0);
                end
            end
        end

        // Last part: a full frame with no idling on either side, so ticks and results
        // move back to back.
        set_half_period(32'd5);
        idle_on = 1'b0;
        random_command(i2cbm_pkg::KIND_START);
        random_command(i2cbm_pkg::KIND_WRITE);
        random_command(i2cbm_pkg::KIND_READ);
        random_command(i2cbm_pkg::KIND_STOP);
        repeat (3) idle_tick(1'b0, 13'd0);

        s_axis_tvalid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d ticks carrying %0d commands over %0d half-period settings.",
                 ticks_sent, cmds_issued, settings_used);
        $display("Checked %0d line results, %0d of them completed reads.",
                 results_checked, reads_seen);
        if (errors == 0) begin
            $display("i2c_bit_level_master_top regression: pass");
        end else begin
            $display("i2c_bit_level_master_top regression: fail");
        end
        $finish;
    end

endmodule

[i2c_bit_level_master_top.f]
+incdir+rtl
rtl/i2cbm_pkg.sv
rtl/i2cbm_step.sv
rtl/i2cbm_out_reg.sv
rtl/i2c_bit_level_master_top.sv
bench/tb_i2c_bit_level_master_top.sv
